[sv/frame_deframer_xor_fold_check_assert.svh]
// Assertion macros for the checker file.
`ifndef FRAME_DEFRAMER_XOR_FOLD_CHECK_ASSERT_SVH
`define FRAME_DEFRAMER_XOR_FOLD_CHECK_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FDX_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdx assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FDX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fdx assertion failed");

`endif

[sv/fdx_pkg.sv]
// Shared types and constants for the frame deframer.
package fdx_pkg;

	localparam int unsigned HDR_BYTES = 8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CSUM = 2'd1;
	localparam logic [1:0] ST_SIZE = 2'd2;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] msg_id;
		logic [7:0]  body_byte;
		logic        byte_valid;
		logic        frame_end;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} stage_t;

endpackage

[sv/frame_deframer_xor_fold_check.sv]
// Frame deframer with XOR-fold checksum check: takes one stream byte per cycle
// (or a restart item) while item_stall is low, parses 8-byte little-endian
// headers (size, message id, checksum) and passes each body byte on with the
// message id; the last body byte, or the header of an empty or undersized
// frame, carries frame_end and the checksum or size verdict. After an error,
// bytes are dropped until a restart item. One item is accepted every cycle
// unless item_stall is high; each item passes an input register and a result
// register, and a stalled result holds both registers back.
module frame_deframer_xor_fold_check
	import fdx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	stage_t stage;
	logic   advance;

	fdx_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (advance),
		.stage      (stage)
	);

	fdx_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage        (stage),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[sv/fdx_in_stage.sv]
// Input register stage of the frame deframer.
module fdx_in_stage
	import fdx_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_stall,
	input  item_t  item,
	input  logic   advance,
	output stage_t stage
);

	logic  vld_s1;
	item_t item_s1;

	// Hold while the occupied register cannot move on.
	assign item_stall = vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	assign stage.vld  = vld_s1;
	assign stage.item = item_s1;

endmodule

[sv/fdx_parser.sv]
// Frame parser: header capture, body fold, checksum verdict, result register.
module fdx_parser
	import fdx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  stage_t  stage,
	output logic    advance,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	typedef enum logic [1:0] {
		PH_HDR  = 2'd0,
		PH_BODY = 2'd1,
		PH_DROP = 2'd2
	} phase_t;

	phase_t      phase_q,  phase_d;
	logic [2:0]  hcnt_q,   hcnt_d;
	logic [15:0] size_q,   size_d;
	logic [15:0] id_q,     id_d;
	logic [31:0] sent_q,   sent_d;
	logic [31:0] fold_q,   fold_d;
	logic [15:0] idx_q,    idx_d;
	logic        res_vld_q, emit;
	result_t     res_q,    res_d;

	logic [7:0]  b;
	logic [15:0] body_len;
	logic [15:0] whole;
	logic [15:0] idx_inc;
	logic [1:0]  lane;
	logic [31:0] fold_nx;
	logic [31:0] sent_hdr;

	assign advance = stage.vld && (!res_vld_q || !result_stall);
	assign b       = stage.item.rx_byte;

	assign body_len = size_q - 16'(HDR_BYTES);
	assign whole    = {body_len[15:2], 2'b00};
	assign idx_inc  = idx_q + 16'd1;
	// Whole words fold by lane; tail bytes land in bits 7..0.
	assign lane     = (idx_q < whole) ? idx_q[1:0] : 2'd0;
	assign sent_hdr = {b, sent_q[23:0]};

	always_comb begin
		case (lane)
			2'd0:    fold_nx = fold_q ^ {24'd0, b};
			2'd1:    fold_nx = fold_q ^ {16'd0, b, 8'd0};
			2'd2:    fold_nx = fold_q ^ {8'd0, b, 16'd0};
			default: fold_nx = fold_q ^ {b, 24'd0};
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		hcnt_d  = hcnt_q;
		size_d  = size_q;
		id_d    = id_q;
		sent_d  = sent_q;
		fold_d  = fold_q;
		idx_d   = idx_q;
		emit    = 1'b0;
		res_d.msg_id     = id_q;
		res_d.body_byte  = 8'd0;
		res_d.byte_valid = 1'b0;
		res_d.frame_end  = 1'b1;
		res_d.status     = ST_OK;

		if (stage.item.mode) begin
			phase_d = PH_HDR;
			hcnt_d  = 3'd0;
			fold_d  = 32'd0;
			idx_d   = 16'd0;
		end else begin
			unique case (phase_q)
				PH_DROP: begin
				end
				PH_BODY: begin
					emit             = 1'b1;
					res_d.body_byte  = b;
					res_d.byte_valid = 1'b1;
					res_d.frame_end  = 1'b0;
					fold_d           = fold_nx;
					idx_d            = idx_inc;
					if (idx_inc == body_len) begin
						res_d.frame_end = 1'b1;
						res_d.status    = (fold_nx != sent_q) ? ST_CSUM : ST_OK;
						phase_d         = (fold_nx != sent_q) ? PH_DROP : PH_HDR;
						hcnt_d          = 3'd0;
						fold_d          = 32'd0;
						idx_d           = 16'd0;
					end
				end
				default: begin
					case (hcnt_q)
						3'd0:    size_d = {8'd0, b};
						3'd1:    size_d = {b, size_q[7:0]};
						3'd2:    id_d   = {8'd0, b};
						3'd3:    id_d   = {b, id_q[7:0]};
						3'd4:    sent_d = {24'd0, b};
						3'd5:    sent_d = {16'd0, b, sent_q[7:0]};
						3'd6:    sent_d = {8'd0, b, sent_q[15:0]};
						default: sent_d = sent_hdr;
					endcase
					if (hcnt_q != 3'd7) begin
						hcnt_d = hcnt_q + 3'd1;
					end else begin
						hcnt_d = 3'd0;
						fold_d = 32'd0;
						idx_d  = 16'd0;
						if (size_q < 16'(HDR_BYTES)) begin
							emit         = 1'b1;
							res_d.status = ST_SIZE;
							phase_d      = PH_DROP;
						end else if (size_q == 16'(HDR_BYTES)) begin
							emit         = 1'b1;
							res_d.status = (sent_hdr != 32'd0) ? ST_CSUM : ST_OK;
							phase_d      = (sent_hdr != 32'd0) ? PH_DROP : PH_HDR;
						end else begin
							phase_d = PH_BODY;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			hcnt_q    <= 3'd0;
			size_q    <= 16'd0;
			id_q      <= 16'd0;
			sent_q    <= 32'd0;
			fold_q    <= 32'd0;
			idx_q     <= 16'd0;
			res_vld_q <= 1'b0;
			res_q     <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			hcnt_q    <= hcnt_d;
			size_q    <= size_d;
			id_q      <= id_d;
			sent_q    <= sent_d;
			fold_q    <= fold_d;
			idx_q     <= idx_d;
			res_vld_q <= emit;
			res_q     <= res_d;
		end else if (!result_stall) begin
			// Drop the result once its transfer completes.
			res_vld_q <= 1'b0;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

[sv/fdx_checker.sv]
// Port-level checker for the frame deframer, with its bind.
`include "frame_deframer_xor_fold_check_assert.svh"

module fdx_checker
	import fdx_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled result holds until its transfer.
	`FDX_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(result))
	// A result without a body byte always closes a frame and carries no byte.
	`FDX_ASSERT_NOW(a_nobyte_end, result_valid && !result.byte_valid, result.frame_end && (result.body_byte == 8'd0))
	// Any error status closes the frame.
	`FDX_ASSERT_NOW(a_err_end, result_valid && (result.status != ST_OK), result.frame_end)
	// Size errors never carry a body byte; status stays a known code.
	`FDX_ASSERT_NOW(a_status, result_valid, (result.status == ST_OK) || (result.status == ST_CSUM) || ((result.status == ST_SIZE) && !result.byte_valid))

endmodule

bind frame_deframer_xor_fold_check fdx_checker u_fdx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

[tb/tb.sv]
// Testbench for the frame deframer: directed table, then random framed traffic checked by a model.
`timescale 1ns / 1ps
module tb;
	import fdx_pkg::*;

	typedef enum logic [1:0] {PS_HEADER, PS_BODY, PS_DROP} parse_state_t;

	typedef struct packed {
		item_t   it;
		logic    typed;
		logic    has_res;
		result_t res;
	} stim_row_t;

	localparam int      RANDOM_ITEMS = 1850;
	localparam int      HOLD_CYCLES  = 64;
	localparam int      DRAIN_CYCLES = 16;
	localparam result_t NO_RES       = '0;
	localparam int      DIR_ROWS     = 28;

	// Typed rows carry their own expectation, the rest go through the model.
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{'{1'b1, 8'hFF}, 1'b1, 1'b0, NO_RES},
		// empty frame, id FFFF, zero checksum
		'{'{1'b0, 8'h08}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'hFF}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'hFF}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b1, 1'b1, '{16'hFFFF, 8'h00, 1'b0, 1'b1, ST_OK}},
		// size zero: size error, then drop
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'hCD}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'hAB}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h11}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h22}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h33}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h44}, 1'b1, 1'b1, '{16'hABCD, 8'h00, 1'b0, 1'b1, ST_SIZE}},
		'{'{1'b0, 8'h5A}, 1'b1, 1'b0, NO_RES},
		'{'{1'b1, 8'h00}, 1'b1, 1'b0, NO_RES},
		// empty frame with a nonzero checksum
		'{'{1'b0, 8'h08}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h00}, 1'b0, 1'b0, NO_RES},
		'{'{1'b0, 8'h80}, 1'b1, 1'b1, '{16'h0000, 8'h00, 1'b0, 1'b1, ST_CSUM}},
		'{'{1'b1, 8'h7E}, 1'b1, 1'b0, NO_RES}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	result_t pending_results[$];
	result_t want_res;
	int      bad_count = 0;
	int      live_items = 0;
	bit      src_idle = 1'b0;
	bit      sink_idle = 1'b0;
	bit      hold_req = 1'b0;

	parse_state_t ps = PS_HEADER;
	logic [2:0]   hdr_cnt = '0;
	logic [15:0]  frm_size = '0;
	logic [15:0]  frm_id = '0;
	logic [15:0]  body_cnt = '0;
	logic [31:0]  hdr_sum = '0;
	logic [31:0]  body_sum = '0;

	frame_deframer_xor_fold_check i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic deframe_predict(input item_t it, output logic has, output result_t r);
		logic [15:0] body_len;
		logic [4:0]  sh;
		has = 1'b0;
		r = NO_RES;
		if (it.mode) begin
			ps = PS_HEADER;
			hdr_cnt = '0;
			body_sum = '0;
			body_cnt = '0;
		end else if (ps == PS_BODY) begin
			body_len = frm_size - 16'(HDR_BYTES);
			// whole words land by byte lane, tail bytes fold into the low byte
			sh = (body_cnt < (body_len & ~16'd3)) ? {body_cnt[1:0], 3'b000} : 5'd0;
			body_sum ^= 32'(it.rx_byte) << sh;
			body_cnt += 16'd1;
			has = 1'b1;
			r.msg_id = frm_id;
			r.body_byte = it.rx_byte;
			r.byte_valid = 1'b1;
			if (body_cnt == body_len) begin
				r.frame_end = 1'b1;
				if (body_sum != hdr_sum) begin
					r.status = ST_CSUM;
					ps = PS_DROP;
				end else
					ps = PS_HEADER;
				hdr_cnt = '0;
				body_sum = '0;
				body_cnt = '0;
			end
		end else if (ps == PS_HEADER) begin
			case (hdr_cnt)
				3'd0: frm_size = {8'd0, it.rx_byte};
				3'd1: frm_size[15:8] = it.rx_byte;
				3'd2: frm_id = {8'd0, it.rx_byte};
				3'd3: frm_id[15:8] = it.rx_byte;
				3'd4: hdr_sum = {24'd0, it.rx_byte};
				3'd5: hdr_sum[15:8] = it.rx_byte;
				3'd6: hdr_sum[23:16] = it.rx_byte;
				default: hdr_sum[31:24] = it.rx_byte;
			endcase
			if (hdr_cnt != 3'd7)
				hdr_cnt += 3'd1;
			else begin
				hdr_cnt = '0;
				body_sum = '0;
				body_cnt = '0;
				if (frm_size <= 16'(HDR_BYTES)) begin
					has = 1'b1;
					r.msg_id = frm_id;
					r.frame_end = 1'b1;
					if (frm_size < 16'(HDR_BYTES)) begin
						r.status = ST_SIZE;
						ps = PS_DROP;
					end else if (hdr_sum != '0) begin
						r.status = ST_CSUM;
						ps = PS_DROP;
					end
				end else
					ps = PS_BODY;
			end
		end
	endtask

	task automatic send_item(input item_t it, input logic typed, input logic typed_has,
			input result_t typed_res);
		result_t r;
		logic    has;
		if (src_idle && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (it.mode || ps != PS_DROP)
			live_items++;
		deframe_predict(it, has, r);
		if (typed) begin
			has = typed_has;
			r = typed_res;
		end
		if (has)
			pending_results.push_back(r);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item('{1'b0, b}, 1'b0, 1'b0, NO_RES);
	endtask

	task automatic send_restart();
		send_item('{1'b1, 8'($urandom)}, 1'b0, 1'b0, NO_RES);
	endtask

	task automatic send_header(input logic [15:0] size, input logic [15:0] id,
			input logic [31:0] sum);
		logic [63:0] hdr;
		hdr = {sum, id, size};
		for (int i = 0; i < 8; i++)
			send_byte(hdr[8 * i +: 8]);
	endtask

	// Leave the drop state: a few ignored bytes, then a restart.
	task automatic send_resync();
		repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
		send_restart();
	endtask

	task automatic send_scenario();
		logic [7:0]  body[$];
		logic [15:0] size;
		logic [15:0] id;
		logic [31:0] sum;
		int          pick;
		int          len;
		int          cut;
		pick = $urandom_range(0, 99);
		id = 16'($urandom);
		if (pick < 75) begin
			// well-formed frame; the top slice gets a corrupted checksum
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
			sum = '0;
			for (int i = 0; i < len; i++) begin
				body.push_back(8'($urandom));
				if (i < (len & ~3))
					sum ^= 32'(body[i]) << (8 * (i % 4));
				else
					sum ^= 32'(body[i]);
			end
			if (pick >= 60)
				sum ^= 32'd1 << $urandom_range(0, 31);
			send_header(16'(len + HDR_BYTES), id, sum);
			foreach (body[i]) send_byte(body[i]);
			if (pick >= 60)
				send_resync();
		end else if (pick < 83) begin
			send_header(16'($urandom_range(0, HDR_BYTES - 1)), id, $urandom);
			send_resync();
		end else if (pick < 91) begin
			// abandon a frame part way through its body
			if ($urandom_range(0, 3) == 0)
				size = 16'hFFFF - 16'($urandom_range(0, 3));
			else
				size = 16'($urandom_range(HDR_BYTES + 1, 65535));
			send_header(size, id, $urandom);
			cut = $urandom_range(0, 20);
			if (cut > int'(size) - int'(HDR_BYTES) - 1)
				cut = int'(size) - int'(HDR_BYTES) - 1;
			repeat (cut) send_byte(8'($urandom));
			send_restart();
		end else if (pick < 96) begin
			repeat ($urandom_range(1, 7)) send_byte(8'($urandom));
			send_restart();
		end else begin
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 3) == 0)
					send_restart();
				else
					send_byte(8'($urandom));
			end
			send_restart();
		end
	endtask

	initial begin
		item_valid <= 1'b0;
		item <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(DIR_TABLE[i].it, DIR_TABLE[i].typed, DIR_TABLE[i].has_res,
				DIR_TABLE[i].res);
		src_idle = 1'b1;
		sink_idle = 1'b1;
		while (live_items < 600) send_scenario();
		// sender flat out while the receiver holds off
		src_idle = 1'b0;
		hold_req = 1'b1;
		while (live_items < 900) send_scenario();
		src_idle = 1'b1;
		sink_idle = 1'b0;
		while (live_items < 1250) send_scenario();
		sink_idle = 1'b1;
		while (live_items < 1600) send_scenario();
		src_idle = 1'b0;
		sink_idle = 1'b0;
		while (live_items < RANDOM_ITEMS) send_scenario();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_count == 0)
			$display("[frame_deframer_xor_fold_check] OK");
		else
			$display("[frame_deframer_xor_fold_check] ERROR");
		$finish;
	end

	initial begin
		int n;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				n = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (sink_idle && $urandom_range(0, 7) == 0)
				n = $urandom_range(1, 14);
			else
				n = 0;
			result_stall <= (n != 0);
			repeat ((n > 1) ? n - 1 : 0) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("%0t unexpected result: id %h byte %h valid %b end %b status %0d",
						$time, result.msg_id, result.body_byte, result.byte_valid,
						result.frame_end, result.status);
			end else begin
				want_res = pending_results.pop_front();
				if (result !== want_res) begin
					bad_count++;
					if (bad_count <= 10)
						$display({"%0t result mismatch: expected id %h byte %h valid %b end %b",
							" status %0d, got id %h byte %h valid %b end %b status %0d"},
							$time, want_res.msg_id, want_res.body_byte, want_res.byte_valid,
							want_res.frame_end, want_res.status, result.msg_id,
							result.body_byte, result.byte_valid, result.frame_end,
							result.status);
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("[frame_deframer_xor_fold_check] ERROR");
		$finish;
	end

endmodule
